@@ rtl/core/hsv2rgb_pkg.sv @@
// Shared types, constants and width helpers for the HSV to RGB converter.
// Depends on nothing; every other file of the converter imports it.
package hsv2rgb_pkg;

  localparam int CHAN_W      = 8;
  localparam int PCT_FULL    = 100;
  localparam int HUE_FULL    = 360;
  localparam int SECTOR_DEG  = 60;
  localparam int NUM_SECTORS = 6;

  // Scaled quotient before the final divide by 600000 (= 100 * 100 * 60).
  // It never exceeds 255 * 600000, which fits in 28 bits.
  localparam int             Q_W         = 28;
  localparam int             RECIP_W     = 29;
  localparam int             RECIP_SHIFT = 48;
  // ceil(2^48 / 600000); exact floor division for every quotient below 2^28.
  localparam logic [RECIP_W-1:0] RECIP_MUL = 29'd469124962;

  typedef logic [CHAN_W-1:0] chan_t;

  // 60-degree hue sectors, named by the primaries they run between.
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    logic    valid;
    logic    err;
    sector_t sector;
  } ctrl_t;

  // Bits for a percent quantity 0 .. 100 * 2^f.
  function automatic int pct_w(int f);
    longint unsigned full;
    full = longint'(PCT_FULL) << f;
    return $clog2(full + 1);
  endfunction

  // Bits for the folded hue fraction 0 .. 60 * 2^f.
  function automatic int frac_w(int f);
    longint unsigned span;
    span = longint'(SECTOR_DEG) << f;
    return $clog2(span + 1);
  endfunction

  // Bits for a channel numerator term 0 .. 6000 * 2^(2f).
  function automatic int inner_w(int f);
    longint unsigned full;
    full = longint'(PCT_FULL * SECTOR_DEG) << (2 * f);
    return $clog2(full + 1);
  endfunction

endpackage

@@ rtl/core/hsv2rgb_front.sv @@
// Front end of the converter: range check, hue sector and fraction, and the
// per-channel numerator terms. Two register stages. Uses hsv2rgb_pkg.
module hsv2rgb_front #(
  parameter int FRAC_BITS = 6
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            take,
  input  logic signed [15:0]                              hue,
  input  logic signed [14:0]                              sat,
  input  logic signed [14:0]                              bri,
  output hsv2rgb_pkg::ctrl_t                              ctrl_o,
  output logic [hsv2rgb_pkg::pct_w(FRAC_BITS)-1:0]        bri_o,
  output logic [hsv2rgb_pkg::inner_w(FRAC_BITS)-1:0]      inner_mid_o,
  output logic [hsv2rgb_pkg::inner_w(FRAC_BITS)-1:0]      inner_lo_o
);
  import hsv2rgb_pkg::*;

  localparam int              V_W     = pct_w(FRAC_BITS);
  localparam int              FRAC_W  = frac_w(FRAC_BITS);
  localparam int              INNER_W = inner_w(FRAC_BITS);
  localparam longint unsigned UNIT    = 64'd1 << FRAC_BITS;
  localparam int              HUE_MAX = int'(HUE_FULL * UNIT);
  localparam int              PCT_MAX = int'(PCT_FULL * UNIT);
  localparam int              SPAN    = int'(SECTOR_DEG * UNIT);

  int                 hue_i;
  int                 sat_i;
  int                 bri_i;
  int                 rem_i;
  logic [2:0]         cnt;
  ctrl_t              ctrl1_nxt;
  logic [FRAC_W-1:0]  frac1_nxt;

  ctrl_t              ctrl1_r;
  logic [V_W-1:0]     sat1_r;
  logic [V_W-1:0]     bri1_r;
  logic [FRAC_W-1:0]  frac1_r;

  ctrl_t              ctrl2_r;
  logic [V_W-1:0]     bri2_r;
  logic [INNER_W-1:0] inner_mid_nxt;
  logic [INNER_W-1:0] inner_lo_nxt;
  logic [INNER_W-1:0] inner_mid_r;
  logic [INNER_W-1:0] inner_lo_r;

  // Stage 1: sector by six parallel threshold compares, then the fraction
  // folded so that odd sectors count down from the sector span.
  always_comb begin
    hue_i = int'(hue);
    sat_i = int'(sat);
    bri_i = int'(bri);
    cnt   = 3'd0;
    for (int k = 1; k <= NUM_SECTORS; k++) begin
      if (hue_i >= k * SPAN) begin
        cnt = cnt + 3'd1;
      end
    end
    rem_i     = hue_i - int'(cnt) * SPAN;
    frac1_nxt = cnt[0] ? FRAC_W'(SPAN - rem_i) : FRAC_W'(rem_i);
    ctrl1_nxt.valid  = take;
    ctrl1_nxt.err    = (hue_i < 0) || (hue_i > HUE_MAX) ||
                       (sat_i < 0) || (sat_i > PCT_MAX) ||
                       (bri_i < 0) || (bri_i > PCT_MAX);
    // Hue of exactly 360 degrees belongs to the last sector.
    ctrl1_nxt.sector = (cnt > 3'd5) ? SEC_MR : sector_t'(cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl1_r <= '0;
      ctrl2_r <= '0;
    end else begin
      ctrl1_r <= ctrl1_nxt;
      ctrl2_r <= ctrl1_r;
    end
  end

  // Stage 2: lo term is span * (full - s), mid adds s * frac.
  always_comb begin
    inner_lo_nxt  = INNER_W'(SPAN) * (INNER_W'(PCT_MAX) - INNER_W'(sat1_r));
    inner_mid_nxt = INNER_W'(sat1_r) * INNER_W'(frac1_r) + inner_lo_nxt;
  end

  always_ff @(posedge clk) begin
    sat1_r      <= V_W'(sat_i);
    bri1_r      <= V_W'(bri_i);
    frac1_r     <= frac1_nxt;
    bri2_r      <= bri1_r;
    inner_mid_r <= inner_mid_nxt;
    inner_lo_r  <= inner_lo_nxt;
  end

  assign ctrl_o      = ctrl2_r;
  assign bri_o       = bri2_r;
  assign inner_mid_o = inner_mid_r;
  assign inner_lo_o  = inner_lo_r;

endmodule

@@ rtl/core/hsv2rgb_scale.sv @@
// One channel of the back end: floor(255 * v * inner / (600000 * 2^(3f))).
// Three register stages: product, scaled quotient, reciprocal divide. Uses hsv2rgb_pkg.
module hsv2rgb_scale #(
  parameter int FRAC_BITS = 6
) (
  input  logic                                       clk,
  input  logic [hsv2rgb_pkg::pct_w(FRAC_BITS)-1:0]   bri,
  input  logic [hsv2rgb_pkg::inner_w(FRAC_BITS)-1:0] inner,
  output hsv2rgb_pkg::chan_t                         chan
);
  import hsv2rgb_pkg::*;

  localparam int V_W     = pct_w(FRAC_BITS);
  localparam int INNER_W = inner_w(FRAC_BITS);
  localparam int P_W     = V_W + INNER_W;
  localparam int SH      = 3 * FRAC_BITS;
  localparam int R_W     = Q_W + RECIP_W;

  logic [P_W-1:0]   prod_r;
  logic [P_W+7:0]   scaled;
  logic [Q_W-1:0]   quo_r;
  logic [R_W-1:0]   rprod;
  chan_t            chan_r;

  // Times 255 as a shift and subtract; the power-of-two part of the
  // denominator is dropped as a shift.
  assign scaled = {prod_r, 8'b0} - (P_W + 8)'(prod_r);
  assign rprod  = R_W'(quo_r) * R_W'(RECIP_MUL);

  always_ff @(posedge clk) begin
    prod_r <= P_W'(bri) * P_W'(inner);
    quo_r  <= scaled[SH +: Q_W];
    chan_r <= rprod[RECIP_SHIFT +: CHAN_W];
  end

  assign chan = chan_r;

endmodule

@@ rtl/core/hsv_to_rgb_unit.sv @@
// HSV to RGB converter. out_valid rises once a request has passed the front, divide and output stages.
// Throughput: one request per clock cycle; the pipeline never stalls, so busy stays low.
// The rate is set by the six-stage pipeline (two front stages, three divide stages, output).
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
// Uses hsv2rgb_pkg, hsv2rgb_front and hsv2rgb_scale.
module hsv_to_rgb_unit #(
  parameter int FRAC_BITS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_hue,
  input  logic signed [14:0] in_saturation,
  input  logic signed [14:0] in_brightness,
  output logic               out_valid,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               out_range_error
);
  import hsv2rgb_pkg::*;

  localparam int              V_W     = pct_w(FRAC_BITS);
  localparam int              INNER_W = inner_w(FRAC_BITS);
  localparam longint unsigned UNIT    = 64'd1 << FRAC_BITS;
  // Numerator term of the brightest channel, C + m = v: span * full scale.
  localparam logic [INNER_W-1:0] INNER_HI =
    INNER_W'(longint'(PCT_FULL * SECTOR_DEG) * UNIT * UNIT);
  localparam int              DIV_STAGES = 3;

  // Every channel value is an exact rational over one common denominator,
  // 600000 * 2^(3*FRAC_BITS). The front end finds the hue sector, the folded
  // fraction inside it and the numerator terms of the three channel levels:
  // the highest (C + m), the middle (X + m) and the lowest (m). Each level then
  // goes through its own scale pipeline, which multiplies by v, by 255, drops
  // the power-of-two part of the denominator and divides the rest by a
  // reciprocal multiplication that is exact over the whole quotient range.

  ctrl_t              front_ctrl;
  logic [V_W-1:0]     front_bri;
  logic [INNER_W-1:0] inner_mid;
  logic [INNER_W-1:0] inner_lo;
  chan_t              lvl_hi;
  chan_t              lvl_mid;
  chan_t              lvl_lo;

  ctrl_t              ctrl_pipe_r [DIV_STAGES];
  ctrl_t              ctrl_out;

  logic               out_valid_r;
  logic               out_err_r;
  chan_t              red_r;
  chan_t              green_r;
  chan_t              blue_r;
  chan_t              red_nxt;
  chan_t              green_nxt;
  chan_t              blue_nxt;

  // The receiver cannot hold results off and every stage moves each cycle,
  // so a new request is taken in every cycle.
  assign busy = 1'b0;

  hsv2rgb_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (start),
    .hue        (in_hue),
    .sat        (in_saturation),
    .bri        (in_brightness),
    .ctrl_o     (front_ctrl),
    .bri_o      (front_bri),
    .inner_mid_o(inner_mid),
    .inner_lo_o (inner_lo)
  );

  hsv2rgb_scale #(
    .FRAC_BITS(FRAC_BITS)
  ) u_scale_hi (
    .clk  (clk),
    .bri  (front_bri),
    .inner(INNER_HI),
    .chan (lvl_hi)
  );

  hsv2rgb_scale #(
    .FRAC_BITS(FRAC_BITS)
  ) u_scale_mid (
    .clk  (clk),
    .bri  (front_bri),
    .inner(inner_mid),
    .chan (lvl_mid)
  );

  hsv2rgb_scale #(
    .FRAC_BITS(FRAC_BITS)
  ) u_scale_lo (
    .clk  (clk),
    .bri  (front_bri),
    .inner(inner_lo),
    .chan (lvl_lo)
  );

  // Valid, error and sector ride alongside the three divide stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        ctrl_pipe_r[i] <= '0;
      end
    end else begin
      ctrl_pipe_r[0] <= front_ctrl;
      for (int i = 1; i < DIV_STAGES; i++) begin
        ctrl_pipe_r[i] <= ctrl_pipe_r[i-1];
      end
    end
  end

  assign ctrl_out = ctrl_pipe_r[DIV_STAGES-1];

  // The sector decides which level lands on which primary. An out-of-range
  // request gives black.
  always_comb begin
    red_nxt   = lvl_hi;
    green_nxt = lvl_lo;
    blue_nxt  = lvl_mid;
    unique case (ctrl_out.sector)
      SEC_RY: begin
        red_nxt = lvl_hi;  green_nxt = lvl_mid; blue_nxt = lvl_lo;
      end
      SEC_YG: begin
        red_nxt = lvl_mid; green_nxt = lvl_hi;  blue_nxt = lvl_lo;
      end
      SEC_GC: begin
        red_nxt = lvl_lo;  green_nxt = lvl_hi;  blue_nxt = lvl_mid;
      end
      SEC_CB: begin
        red_nxt = lvl_lo;  green_nxt = lvl_mid; blue_nxt = lvl_hi;
      end
      SEC_BM: begin
        red_nxt = lvl_mid; green_nxt = lvl_lo;  blue_nxt = lvl_hi;
      end
      SEC_MR: begin
        red_nxt = lvl_hi;  green_nxt = lvl_lo;  blue_nxt = lvl_mid;
      end
      default: begin
        red_nxt = lvl_hi;  green_nxt = lvl_lo;  blue_nxt = lvl_mid;
      end
    endcase
    if (ctrl_out.err) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_err_r <= ctrl_out.err;
    red_r     <= red_nxt;
    green_r   <= green_nxt;
    blue_r    <= blue_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_range_error = out_err_r;
  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;

endmodule
